FILE: design/gfpm_pkg.sv
// Package: shared types, constants and helpers of the gated frequency and period meter.
package gfpm_pkg;

    localparam int COUNT_BITS     = 24;
    localparam int DISPLAY_DIGITS = 7;
    localparam int BCD_BITS       = 4 * DISPLAY_DIGITS;
    localparam int BLANK_BITS     = 3;
    localparam int PERIOD_BITS    = 20;
    localparam int GATE_BITS      = 18;
    localparam int PRESC_BITS     = 9;
    localparam int DIVIDEND_BITS  = 30;

    localparam logic [GATE_BITS-1:0]     GATE_RESET     = 18'd65536;
    localparam logic [PRESC_BITS-1:0]    PRESCALE_RESET = 9'd2;
    localparam logic [PRESC_BITS-1:0]    PRESCALE_MAX   = 9'd256;
    localparam logic [COUNT_BITS-1:0]    DISPLAY_MAX    = 24'd9999999;
    localparam logic [COUNT_BITS-1:0]    UNIT_LIMIT     = 24'd1000;
    localparam logic [DIVIDEND_BITS-1:0] NS_DIVIDEND    = 30'd1000000000;
    localparam logic [DIVIDEND_BITS-1:0] US_DIVIDEND    = 30'd1000000;

    // configuration register indexes
    localparam logic REG_GATE_LENGTH    = 1'b0;
    localparam logic REG_INPUT_PRESCALE = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO      = 2'd1;
    localparam logic [1:0] STATUS_OVERRANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_BCD,
        ST_OUT
    } state_t;

    // leading zero digits, the units digit is never blanked
    function automatic logic [BLANK_BITS-1:0] blank_count(input logic [BCD_BITS-1:0] bcd);
        logic [BLANK_BITS-1:0] n;
        logic                  seen;
        n    = '0;
        seen = 1'b0;
        for (int k = DISPLAY_DIGITS - 1; k > 0; k--)
        begin
            if (bcd[4*k +: 4] != 4'd0)
            begin
                seen = 1'b1;
            end
            if (!seen)
            begin
                n = n + 1'b1;
            end
        end
        return n;
    endfunction

endpackage

FILE: design/gfpm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module gfpm_div
    import gfpm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [COUNT_BITS-1:0]    divisor,
    output logic [PERIOD_BITS-1:0]   quotient,
    output logic                     done
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]    rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [COUNT_BITS-1:0]    dvs_reg, dvs_next;
    logic [COUNT_BITS:0]      trial;
    logic [COUNT_BITS:0]      diff;
    logic                     ge;

    // one trial subtraction per cycle
    assign trial = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(DIVIDEND_BITS - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg[PERIOD_BITS-1:0];
    assign done     = done_reg;

endmodule

FILE: design/gfpm_bcd.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
module gfpm_bcd
    import gfpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] value,
    output logic [BCD_BITS-1:0]   bcd,
    output logic                  done
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] val_reg, val_next;
    logic [BCD_BITS-1:0]   dig_reg, dig_next;
    logic [BCD_BITS-1:0]   adj;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int k = 0; k < DISPLAY_DIGITS; k++)
        begin
            adj[4*k +: 4] = (dig_reg[4*k +: 4] >= 4'd5) ? dig_reg[4*k +: 4] + 4'd3
                                                         : dig_reg[4*k +: 4];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        dig_next  = dig_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(COUNT_BITS - 1);
            val_next  = value;
            dig_next  = '0;
        end
        else if (busy_reg)
        begin
            dig_next = {adj[BCD_BITS-2:0], val_reg[COUNT_BITS-1]};
            val_next = {val_reg[COUNT_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        dig_reg <= dig_next;
    end

    assign bcd  = dig_reg;
    assign done = done_reg;

endmodule

FILE: design/gated_frequency_period_meter_unit.sv
// Sequence: a closing tick starts the divider, then both BCD converters, then the output load.
// Throughput: one sample per cycle while idle between gates; after a closing tick none is
// taken until the result is loaded (30 serial divider steps, 24 serial BCD steps, sequencing),
// and the load waits on any output stall; the divider and BCD shifters take one bit per cycle.
// Reset: asynchronous, active low; counters cleared, registers to 65536 and 2, output empty.
module gated_frequency_period_meter_unit
    import gfpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [GATE_BITS-1:0]  cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] signal_edge, [1] ref_tick
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [23:0] event_count, [51:24] count_bcd, [54:52] count_blank,
    // [74:55] period_value, [102:75] period_bcd, [105:103] period_blank
    output logic [111:0]          m_tdata,
    output logic [2:0]            m_tuser    // [0] period_unit, [2:1] status
);

    state_t                  state_reg, state_next;
    logic [GATE_BITS-1:0]    gate_len_reg;
    logic [PRESC_BITS-1:0]   presc_reg;
    logic [7:0]              presc_cnt_reg, presc_cnt_next;
    logic [COUNT_BITS-1:0]   edge_cnt_reg, edge_cnt_next;
    logic [GATE_BITS-1:0]    gate_cnt_reg, gate_cnt_next;
    logic                    ovf_reg, ovf_next;
    logic [COUNT_BITS-1:0]   count_reg;
    logic                    cnt_ovf_reg;
    logic                    out_valid_reg;
    logic [111:0]            out_data_reg;
    logic [2:0]              out_user_reg;

    logic                    accept;
    logic                    sig_edge;
    logic                    ref_tick;
    logic [PRESC_BITS-1:0]   ratio;
    logic [GATE_BITS-1:0]    gate_eff;
    logic                    close;
    logic                    load;
    logic                    div_done;
    logic                    bcd_done;
    logic                    bcd_p_done;
    logic [PERIOD_BITS-1:0]  quotient;
    logic [PERIOD_BITS-1:0]  period;
    logic [COUNT_BITS-1:0]   count_sat;
    logic [BCD_BITS-1:0]     count_bcd;
    logic [BCD_BITS-1:0]     period_bcd;
    logic                    unit;
    logic [1:0]              status;

    assign accept   = s_tvalid && s_tready;
    assign sig_edge = s_tdata[0];
    assign ref_tick = s_tdata[1];

    // effective prescale ratio and gate length
    always_comb
    begin
        priority if (presc_reg == '0)
            ratio = PRESC_BITS'(1);
        else if (presc_reg > PRESCALE_MAX)
            ratio = PRESCALE_MAX;
        else
            ratio = presc_reg;
        gate_eff = (gate_len_reg == '0) ? GATE_BITS'(1) : gate_len_reg;
    end

    // prescaler, event counter and gate counter
    always_comb
    begin
        presc_cnt_next = presc_cnt_reg;
        edge_cnt_next  = edge_cnt_reg;
        gate_cnt_next  = gate_cnt_reg;
        ovf_next       = ovf_reg;
        close          = 1'b0;
        if (accept && sig_edge)
        begin
            if ({1'b0, presc_cnt_reg} + 9'd1 >= ratio)
            begin
                presc_cnt_next = '0;
                if (edge_cnt_reg == '1)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    edge_cnt_next = edge_cnt_reg + 1'b1;
                    if (edge_cnt_next == '1)
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            else
            begin
                presc_cnt_next = presc_cnt_reg + 8'd1;
            end
        end
        if (accept && ref_tick)
        begin
            if ({1'b0, gate_cnt_reg} + 19'd1 < {1'b0, gate_eff})
            begin
                gate_cnt_next = gate_cnt_reg + 1'b1;
            end
            else
            begin
                close = 1'b1;
            end
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (close)    state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_BCD;
            ST_BCD:  if (bcd_done) state_next = ST_OUT;
            ST_OUT:  if (load)     state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        s_tready = 1'b0;
        load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_OUT:  load     = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    // result fields
    assign unit      = count_reg >= UNIT_LIMIT;
    assign period    = (count_reg == '0) ? '0 : quotient;
    assign count_sat = (count_reg > DISPLAY_MAX) ? DISPLAY_MAX : count_reg;

    always_comb
    begin
        priority if (count_reg == '0)
            status = STATUS_ZERO;
        else if (cnt_ovf_reg || count_reg > DISPLAY_MAX)
            status = STATUS_OVERRANGE;
        else
            status = STATUS_OK;
    end

    gfpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (close),
        .dividend ((edge_cnt_next >= UNIT_LIMIT) ? NS_DIVIDEND : US_DIVIDEND),
        .divisor  (edge_cnt_next),
        .quotient (quotient),
        .done     (div_done)
    );

    gfpm_bcd u_bcd_count (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_done),
        .value (count_sat),
        .bcd   (count_bcd),
        .done  (bcd_done)
    );

    gfpm_bcd u_bcd_period (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_done),
        .value (COUNT_BITS'(period)),
        .bcd   (period_bcd),
        .done  (bcd_p_done)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gate_len_reg  <= GATE_RESET;
            presc_reg     <= PRESCALE_RESET;
            presc_cnt_reg <= '0;
            edge_cnt_reg  <= '0;
            gate_cnt_reg  <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_GATE_LENGTH:    gate_len_reg <= cfg_data;
                    REG_INPUT_PRESCALE: presc_reg    <= cfg_data[PRESC_BITS-1:0];
                    default: ;
                endcase
            end
            if (close)
            begin
                presc_cnt_reg <= '0;
                edge_cnt_reg  <= '0;
                gate_cnt_reg  <= '0;
                ovf_reg       <= 1'b0;
            end
            else
            begin
                presc_cnt_reg <= presc_cnt_next;
                edge_cnt_reg  <= edge_cnt_next;
                gate_cnt_reg  <= gate_cnt_next;
                ovf_reg       <= ovf_next;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // captured count and output register
    always_ff @(posedge clk)
    begin
        if (close)
        begin
            count_reg   <= edge_cnt_next;
            cnt_ovf_reg <= ovf_next;
        end
        if (load)
        begin
            out_data_reg <= {6'd0, blank_count(period_bcd), period_bcd, period,
                             blank_count(count_bcd), count_bcd, count_reg};
            out_user_reg <= {status, unit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // checks
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("sample taken while a result is in progress");
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its phase");
    a_bcd_in_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        bcd_done |-> (state_reg == ST_BCD) && bcd_p_done)
        else $error("BCD converters out of step");
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

FILE: tb/testbench.sv
// Testbench of the gated frequency and period meter: self-predicting stream test.
module testbench;
    import gfpm_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_addr;
    logic [GATE_BITS-1:0] cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [111:0]         m_tdata;
    logic [2:0]           m_tuser;

    typedef struct packed {
        logic [23:0] count;
        logic [27:0] cbcd;
        logic [2:0]  cblank;
        logic [19:0] period;
        logic [27:0] pbcd;
        logic [2:0]  pblank;
        logic        unit;
        logic [1:0]  status;
    } reading_t;

    // meter model state
    logic [GATE_BITS-1:0]  gate_reg;
    logic [PRESC_BITS-1:0] presc_reg;
    int unsigned           presc_cnt;
    int unsigned           edge_cnt;
    int unsigned           tick_cnt;
    bit                    sat_flag;

    reading_t    readings_due[$];
    int          fail_count;
    int          reading_count;
    int          idle_cycles;
    bit          hold_rx;
    int          item_count;

    gated_frequency_period_meter_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // decimal digits with saturation and leading blank count
    function automatic void digits(input longint unsigned v, output logic [27:0] bcd,
                                   output logic [2:0] blank);
        logic [3:0] d [DISPLAY_DIGITS];
        bit         seen;
        bcd   = '0;
        blank = '0;
        seen  = 1'b0;
        if (v > 64'd9999999)
        begin
            v = 64'd9999999;
        end
        for (int k = 0; k < DISPLAY_DIGITS; k++)
        begin
            d[k] = 4'(v % 10);
            v    = v / 10;
            bcd[4*k +: 4] = d[k];
        end
        for (int k = DISPLAY_DIGITS - 1; k > 0; k--)
        begin
            if (d[k] != 0)
            begin
                seen = 1'b1;
            end
            if (!seen)
            begin
                blank = blank + 1'b1;
            end
        end
    endfunction

    // advance the meter by one sample, queue a reading when a gate closes
    task automatic meter_sample(input bit edge_in, input bit tick_in);
        int unsigned     ratio;
        int unsigned     gate;
        longint unsigned per;
        reading_t        r;
        ratio = (presc_reg == 0) ? 1 : ((presc_reg > 256) ? 256 : presc_reg);
        gate  = (gate_reg == 0) ? 1 : gate_reg;
        if (edge_in)
        begin
            if (presc_cnt + 1 >= ratio)
            begin
                presc_cnt = 0;
                if (edge_cnt >= 24'hFFFFFF)
                begin
                    sat_flag = 1'b1;
                end
                else
                begin
                    edge_cnt++;
                    if (edge_cnt == 24'hFFFFFF)
                    begin
                        sat_flag = 1'b1;
                    end
                end
            end
            else
            begin
                presc_cnt = (presc_cnt + 1) & 8'hFF;
            end
        end
        if (tick_in)
        begin
            if (tick_cnt + 1 < gate)
            begin
                tick_cnt = (tick_cnt + 1) & 18'h3FFFF;
            end
            else
            begin
                r.count = COUNT_BITS'(edge_cnt);
                if (edge_cnt == 0)
                begin
                    r.status = STATUS_ZERO;
                    per      = 0;
                    r.unit   = 1'b0;
                end
                else
                begin
                    r.status = (sat_flag || edge_cnt > 9999999) ? STATUS_OVERRANGE : STATUS_OK;
                    if (edge_cnt < 1000)
                    begin
                        per    = 1000000 / edge_cnt;
                        r.unit = 1'b0;
                    end
                    else
                    begin
                        per    = 1000000000 / edge_cnt;
                        r.unit = 1'b1;
                    end
                end
                r.period = PERIOD_BITS'(per);
                digits(edge_cnt, r.cbcd, r.cblank);
                digits(per, r.pbcd, r.pblank);
                readings_due.push_back(r);
                tick_cnt  = 0;
                edge_cnt  = 0;
                presc_cnt = 0;
                sat_flag  = 1'b0;
            end
        end
    endtask

    // offer one sample with a random gap before it
    task automatic send_sample(input bit edge_in, input bit tick_in, input int gap_pct = 20);
        int gap;
        gap = 0;
        if ($urandom_range(99) < gap_pct)
        begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap)
            begin
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, tick_in, edge_in};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        meter_sample(edge_in, tick_in);
        item_count++;
    endtask

    // write a register once every reading is out and the block has settled
    task automatic write_reg(input logic idx, input int unsigned val);
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (70)
        begin
            @(posedge clk);
        end
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= GATE_BITS'(val);
        @(posedge clk);
        cfg_we   <= 1'b0;
        if (idx == REG_GATE_LENGTH)
        begin
            gate_reg = GATE_BITS'(val);
        end
        else
        begin
            presc_reg = PRESC_BITS'(val);
        end
    endtask

    // receiver: random back-pressure, with an optional long hold
    always @(posedge clk)
    begin
        if (!rst_n || hold_rx)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) < 75);
        end
    end

    // compare each accepted reading with the oldest prediction
    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[23:0], m_tdata[51:24], m_tdata[54:52], m_tdata[74:55],
                   m_tdata[102:75], m_tdata[105:103], m_tuser[0], m_tuser[2:1]};
            reading_count++;
            if (readings_due.size() == 0)
            begin
                $display("%0t: unexpected reading %h", $time, got);
                fail_count++;
            end
            else
            begin
                want = readings_due.pop_front();
                if (got.count != want.count)
                    $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
                if (got.cbcd != want.cbcd)
                    $display("%0t: count_bcd exp %h got %h", $time, want.cbcd, got.cbcd);
                if (got.cblank != want.cblank)
                    $display("%0t: count_blank exp %0d got %0d", $time, want.cblank, got.cblank);
                if (got.period != want.period)
                    $display("%0t: period exp %0d got %0d", $time, want.period, got.period);
                if (got.pbcd != want.pbcd)
                    $display("%0t: period_bcd exp %h got %h", $time, want.pbcd, got.pbcd);
                if (got.pblank != want.pblank)
                    $display("%0t: period_blank exp %0d got %0d", $time, want.pblank,
                             got.pblank);
                if (got.unit != want.unit)
                    $display("%0t: unit exp %0d got %0d", $time, want.unit, got.unit);
                if (got.status != want.status)
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                if (got != want)
                begin
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // directed: gate and prescale extremes, closing-tick edge, zero count
    task automatic test_directed();
        write_reg(REG_GATE_LENGTH, 0);
        write_reg(REG_INPUT_PRESCALE, 0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        write_reg(REG_GATE_LENGTH, 3);
        write_reg(REG_INPUT_PRESCALE, 9'h1FF);
        for (int i = 0; i < 8; i++)
        begin
            send_sample(1'b1, i[0]);
        end
        write_reg(REG_INPUT_PRESCALE, 256);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b1);
    endtask

    // lowered prescale while edges are pending
    task automatic test_prescale_drop();
        write_reg(REG_GATE_LENGTH, 4);
        write_reg(REG_INPUT_PRESCALE, 8);
        repeat (5)
        begin
            send_sample(1'b1, 1'b0);
        end
        write_reg(REG_INPUT_PRESCALE, 3);
        send_sample(1'b1, 1'b0);
        repeat (4)
        begin
            send_sample(1'b1, 1'b1);
        end
    endtask

    // counts up to and past the unit boundary with dense edges
    task automatic test_unit_boundary();
        write_reg(REG_INPUT_PRESCALE, 1);
        write_reg(REG_GATE_LENGTH, 1);
        repeat (1003)
        begin
            send_sample(1'b1, 1'b0, 0);
        end
        send_sample(1'b1, 1'b1);
    endtask

    // random samples under a mix of settings; one stretch holds the receiver off
    task automatic test_random();
        int unsigned n_edge;
        int unsigned n_tick;
        for (int phase = 0; phase < 12; phase++)
        begin
            write_reg(REG_GATE_LENGTH, (phase == 11) ? 131072 : $urandom_range(6, 1));
            write_reg(REG_INPUT_PRESCALE, (phase % 4 == 0) ? $urandom_range(511) :
                      $urandom_range(4, 1));
            n_edge = $urandom_range(90, 20);
            n_tick = $urandom_range(50, 10);
            if (phase == 5)
            begin
                fork
                    begin
                        hold_rx = 1'b1;
                        repeat (600)
                        begin
                            @(posedge clk);
                        end
                        hold_rx = 1'b0;
                    end
                join_none
            end
            for (int i = 0; i < 35; i++)
            begin
                send_sample($urandom_range(99) < n_edge, $urandom_range(99) < n_tick,
                            (phase % 3 == 2) ? 0 : 20);
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        hold_rx   = 1'b0;
        gate_reg  = 65536;
        presc_reg = 2;
        presc_cnt = 0;
        edge_cnt  = 0;
        tick_cnt  = 0;
        sat_flag  = 1'b0;
        fail_count    = 0;
        reading_count = 0;
        idle_cycles   = 0;
        item_count    = 0;
        repeat (12)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);
        // a few samples on the reset settings
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
        test_directed();
        test_prescale_drop();
        test_unit_boundary();
        test_random();
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100)
        begin
            @(posedge clk);
        end
        $display("Run covered %0d samples and %0d gate readings over gate, prescale,",
                 item_count, reading_count);
        $display("unit-boundary and back-pressure cases.");
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
